/* rtl/mlp_forward_argmax_assert.svh */
// Assertion macros used by the checker file.
`ifndef MLP_FORWARD_ARGMAX_ASSERT_SVH
`define MLP_FORWARD_ARGMAX_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the following cycle.
`define MFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/mfa_pkg.sv */
// ----------------------------------------------------------------------------
// mfa_pkg
// Types, constants and the sigmoid helpers for the perceptron block.
// ----------------------------------------------------------------------------
package mfa_pkg;

  localparam int InputsDef  = 54;
  localparam int HiddenDef  = 50;
  localparam int OutputsDef = 12;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_INPUT  = 2'd2,
    OP_RUN    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         target_layer;
    logic [5:0]         neuron_index;
    logic [5:0]         source_index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         best_index;
    logic signed [15:0] best_state;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_MAC,
    ST_ROUND,
    ST_ACT,
    ST_NEXT,
    ST_DONE
  } state_t;

  // Control handed from the sequencer to the cell row.
  typedef struct packed {
    logic mac;
    logic shift_in;
  } cell_ctl_t;

  // Rounded Q32.32 product used by the exponential below.
  function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b + 128'h8000_0000;
    return p[95:32];
  endfunction

  // e^(-e/256) in unsigned Q32.32 by rounded square and multiply. It is only
  // evaluated while the sigmoid table constants are elaborated.
  function automatic logic [63:0] exp_q32(input int e);
    logic [63:0] r;
    logic [63:0] b;
    int k;
    r = 64'h1_0000_0000;
    b = 64'd4278222805;
    k = e;
    while (k != 0) begin
      if ((k & 1) != 0) r = q32_mul(r, b);
      b = q32_mul(b, b);
      k = k >> 1;
    end
    return r;
  endfunction

endpackage

/* rtl/mlp_forward_argmax.sv */
// ----------------------------------------------------------------------------
// mlp_forward_argmax
// The block stores weights, biases and inputs from write transfers, one per
// cycle, and on a run transfer evaluates the three layers one neuron at a
// time. Each layer starts by shifting its source values into a row of 64
// cells. A neuron then loads its bias, accumulates one product per source
// value, and rounds, activates and stores the result; the row rotates so
// that the single weight memory port is the only memory read in the dot
// product. No transfer is accepted while a run is in progress or while a
// result waits to be taken.
// ----------------------------------------------------------------------------
module mlp_forward_argmax
  import mfa_pkg::*;
#(
  parameter int INPUTS  = InputsDef,
  parameter int HIDDEN  = HiddenDef,
  parameter int OUTPUTS = OutputsDef
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int WDepth = INPUTS * HIDDEN + HIDDEN * HIDDEN + HIDDEN * OUTPUTS;
  localparam int NDepth = 2 * HIDDEN + OUTPUTS;
  localparam int WW     = $clog2(WDepth);
  localparam int NW     = $clog2(NDepth);
  localparam int Cells  = 64;

  logic signed [15:0] wmem [WDepth];
  logic signed [15:0] bmem [NDepth];
  logic signed [15:0] amem [NDepth];
  logic signed [15:0] imem [INPUTS];

  state_t state_r, state_nxt;
  logic [1:0]  layer_r, layer_nxt;
  logic [6:0]  n_r, n_nxt;        // neuron within layer
  logic [6:0]  s_r, s_nxt;        // source within dot product / load count
  logic [WW:0] wa_r, wa_nxt;
  logic        loading_r, loading_nxt;
  logic signed [40:0] acc_r;
  logic signed [15:0] x_r, act_r;
  logic signed [15:0] wq_r, bq_r;
  logic signed [15:0] ld_r;
  logic signed [15:0] best_r;
  logic [3:0]  bidx_r;
  logic        out_valid_r;

  cell_ctl_t ctl;
  logic signed [15:0] row [Cells];

  logic [6:0] nprev, ncnt;
  logic [NW:0] nbase, pbase;

  always_comb begin
    unique case (layer_r)
      2'd1:    begin nprev = 7'(INPUTS); ncnt = 7'(HIDDEN); nbase = '0;
                     pbase = '0; end
      2'd2:    begin nprev = 7'(HIDDEN); ncnt = 7'(HIDDEN); nbase = (NW+1)'(HIDDEN);
                     pbase = '0; end
      default: begin nprev = 7'(HIDDEN); ncnt = 7'(OUTPUTS);
                     nbase = (NW+1)'(2 * HIDDEN); pbase = (NW+1)'(HIDDEN); end
    endcase
  end

  // ---------------- write decoding ----------------
  logic [6:0] sz_t, sz_p;
  logic [WW:0] wb_t;
  logic [NW:0] nb_t;
  always_comb begin
    unique case (in_data.target_layer)
      2'd1:    begin sz_t = 7'(HIDDEN); sz_p = 7'(INPUTS); wb_t = '0; nb_t = '0; end
      2'd2:    begin sz_t = 7'(HIDDEN); sz_p = 7'(HIDDEN);
                     wb_t = (WW+1)'(INPUTS * HIDDEN); nb_t = (NW+1)'(HIDDEN); end
      default: begin sz_t = 7'(OUTPUTS); sz_p = 7'(HIDDEN);
                     wb_t = (WW+1)'(INPUTS * HIDDEN + HIDDEN * HIDDEN);
                     nb_t = (NW+1)'(2 * HIDDEN); end
    endcase
  end

  logic acc_in;
  logic [WW:0] waddr_w;
  logic [12:0] wprod;
  assign acc_in  = in_valid && in_ready;
  assign wprod   = 13'(in_data.neuron_index) * 13'(sz_p);
  assign waddr_w = wb_t + (WW+1)'(wprod) + (WW+1)'(in_data.source_index);

  always_ff @(posedge clk) begin
    if (acc_in && in_data.target_layer != 2'd0) begin
      if (in_data.opcode == OP_WEIGHT && 7'(in_data.neuron_index) < sz_t &&
          7'(in_data.source_index) < sz_p)
        wmem[waddr_w[WW-1:0]] <= in_data.value;
      if (in_data.opcode == OP_BIAS && 7'(in_data.neuron_index) < sz_t)
        bmem[NW'(nb_t + (NW+1)'(in_data.neuron_index))] <= in_data.value;
    end
    if (acc_in && in_data.opcode == OP_INPUT && 7'(in_data.neuron_index) < 7'(INPUTS))
      imem[in_data.neuron_index] <= in_data.value;
  end

  // ---------------- memory reads ----------------
  // Weight and bias addresses come from the next-state values so that the
  // registered data belongs to the cycle that uses it.
  always_ff @(posedge clk) begin
    wq_r <= wmem[wa_nxt[WW-1:0]];
    bq_r <= bmem[NW'(nbase + (NW+1)'(n_nxt))];
    if (layer_r == 2'd1)
      ld_r <= imem[$clog2(INPUTS)'(s_r < 7'(INPUTS) ? s_r : 7'd0)];
    else
      ld_r <= amem[NW'(pbase + (NW+1)'(s_r))];
  end

  // ---------------- cell row ----------------
  // During loading, values enter at the tail; during a dot product the row
  // rotates over nprev cells so the head always holds the current source.
  assign ctl.mac       = (state_r == ST_MAC) && !loading_r;
  assign ctl.shift_in  = (state_r == ST_MAC) && loading_r;

  for (genvar c = 0; c < Cells; c++) begin : g_row
    localparam int Nb = (c == Cells - 1) ? 0 : c + 1;
    logic signed [15:0] pv, lv;
    assign pv = (7'(c) == nprev - 7'd1) ? row[0] : row[Nb];
    assign lv = (7'(c) == nprev - 7'd1) ? ld_r : row[Nb];
    mfa_cell u_cell (.clk(clk), .ctl(ctl), .prev_val(pv), .load_val(lv),
                     .val(row[c]));
  end

  // ---------------- sigmoid table ----------------
  // Entry t is the sigmoid of the center of bin t in unsigned Q0.16.
  logic [16:0] sig_rom [256];
  for (genvar t = 0; t < 256; t++) begin : g_sig
    localparam int          Mid = 16 * t - 2040;
    localparam logic [63:0] Pw  = exp_q32((Mid < 0) ? -Mid : Mid);
    localparam logic [63:0] Den = 64'h1_0000_0000 + Pw;
    localparam logic [63:0] Num = (Mid >= 0) ? 64'h1_0000_0000_0000 : (Pw << 16);
    localparam logic [16:0] Ent = 17'((Num + (Den >> 1)) / Den);
    assign sig_rom[t] = Ent;
  end

  // ---------------- sequencer ----------------
  // Per layer: load phase shifts nprev values, read through a register, into the row.
  // Per neuron: ST_BIAS reads bias, ST_MAC accumulates nprev products,
  // ST_ROUND saturates, ST_ACT applies x*sigmoid(x), ST_NEXT stores.
  always_comb begin
    state_nxt   = state_r;
    layer_nxt   = layer_r;
    n_nxt       = n_r;
    s_nxt       = s_r;
    wa_nxt      = wa_r;
    loading_nxt = loading_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_in && in_data.opcode == OP_RUN) begin
          state_nxt = ST_MAC; layer_nxt = 2'd1; n_nxt = '0; s_nxt = '0;
          wa_nxt = '0; loading_nxt = 1'b1;
        end
      end
      ST_MAC: begin
        if (loading_r) begin
          s_nxt = s_r + 7'd1;
          if (s_r == nprev) begin
            loading_nxt = 1'b0; s_nxt = '0; state_nxt = ST_BIAS;
          end
        end else begin
          s_nxt  = s_r + 7'd1;
          wa_nxt = wa_r + (WW+1)'(1);
          if (s_r == nprev - 7'd1) state_nxt = ST_ROUND;
        end
      end
      ST_BIAS:  state_nxt = ST_MAC;
      ST_ROUND: state_nxt = ST_ACT;
      ST_ACT:   state_nxt = ST_NEXT;
      ST_NEXT: begin
        s_nxt = '0;
        if (n_r == ncnt - 7'd1) begin
          n_nxt = '0;
          if (layer_r == 2'd3) state_nxt = ST_DONE;
          else begin
            layer_nxt = layer_r + 2'd1; loading_nxt = 1'b1; state_nxt = ST_MAC;
          end
        end else begin
          n_nxt = n_r + 7'd1; state_nxt = ST_BIAS;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; layer_r <= 2'd1; n_r <= '0; s_r <= '0;
      wa_r <= '0; loading_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; layer_r <= layer_nxt; n_r <= n_nxt; s_r <= s_nxt;
      wa_r <= wa_nxt; loading_r <= loading_nxt;
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // ---------------- datapath ----------------
  // The weight read is issued in the preceding cycle (ST_BIAS for the first product) so the product pairs
  // the registered weight with the head cell.
  logic signed [31:0] prod;
  assign prod = wq_r * row[0];

  logic signed [40:0] rsum;
  logic signed [15:0] xsat, xc;
  logic [16:0] sg;
  logic signed [33:0] aprod;
  logic signed [33:0] around;

  assign rsum = (acc_r + 41'sd128) >>> 8;
  assign xsat = (rsum > 41'sd32767) ? 16'sh7fff :
                (rsum < -41'sd32768) ? 16'sh8000 : rsum[15:0];
  assign xc   = (x_r < -16'sd2048) ? -16'sd2048 : (x_r > 16'sd2047 ? 16'sd2047 : x_r);
  assign sg   = sig_rom[8'((xc + 16'sd2048) >>> 4)];
  assign aprod  = 34'(x_r) * $signed({1'b0, sg});
  assign around = (aprod + 34'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (state_r == ST_BIAS) acc_r <= 41'(bq_r) <<< 8;
    else if (ctl.mac) acc_r <= acc_r + 41'(prod);
    if (state_r == ST_ROUND) x_r <= xsat;
    if (state_r == ST_ACT) act_r <= around[15:0];
    if (state_r == ST_NEXT) begin
      amem[NW'(nbase + (NW+1)'(n_r))] <= act_r;
      if (layer_r == 2'd3 && (n_r == '0 || act_r > best_r)) begin
        best_r <= act_r; bidx_r <= n_r[3:0];
      end
    end
  end

  assign in_ready = (state_r == ST_IDLE) && !(out_valid_r && !out_ready);
  assign out_valid = out_valid_r;
  assign out_data.best_index = bidx_r;
  assign out_data.best_state = best_r;

endmodule

/* rtl/mfa_cell.sv */
// ----------------------------------------------------------------------------
// mfa_cell
// One stage of the activation row: holds one value of the previous layer and
// passes it to its neighbor while the dot product walks the row.
// ----------------------------------------------------------------------------
module mfa_cell
  import mfa_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic signed [15:0] prev_val,
  input  logic signed [15:0] load_val,
  output logic signed [15:0] val
);

  logic signed [15:0] val_r;

  // In a dot product the first nprev cells rotate, so each of them presents each value in turn.
  always_ff @(posedge clk) begin
    if (ctl.shift_in) begin
      val_r <= load_val;
    end else if (ctl.mac) begin
      val_r <= prev_val;
    end
  end

  assign val = val_r;

endmodule

/* rtl/mfa_checker.sv */
// ----------------------------------------------------------------------------
// mfa_checker
// Port-level checks for the perceptron block.
// ----------------------------------------------------------------------------
`include "mlp_forward_argmax_assert.svh"
module mfa_checker
  import mfa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  logic in_xfer, out_wait, run_xfer, write_xfer;
  assign in_xfer    = in_valid && in_ready;
  assign out_wait   = out_valid && !out_ready;
  assign run_xfer   = in_xfer && in_data.opcode == OP_RUN;
  assign write_xfer = in_xfer && in_data.opcode != OP_RUN;

  `MFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_data))
  `MFA_ASSERT_NEXT(a_run_busy, clk, rst_n, run_xfer, !in_ready && !out_valid)
  `MFA_ASSERT_NEXT(a_write_quiet, clk, rst_n, write_xfer && !out_valid, !out_valid)
  `MFA_ASSERT_IMPL(a_idx_range, clk, rst_n, out_valid, int'(out_data.best_index) < OutputsDef)
endmodule

bind mlp_forward_argmax mfa_checker u_mfa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data));
